// File: hw/rtl/tdgs_pkg.sv
// ============================================================================
// tdgs_pkg
// Shared types and constants for the tile darkness gradient shader.
// ============================================================================
package tdgs_pkg;

   // Field widths fixed by the interface
   localparam int DARK_W     = 8;
   localparam int TILE_W     = 6;
   localparam int PIX_W      = 7;
   localparam int NBR_W      = 4;
   localparam int LG_CSR_W   = 3;
   localparam int DIM_CSR_W  = 7;
   localparam int LG_RAW_W   = 4;   // holds the tile log2 clamp bound
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_SIZE_LOG2 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHTING_MODE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT     = 2'd3;

   // Lighting modes
   localparam logic LT_TILE       = 1'b0;
   localparam logic LT_PIXEL_BEST = 1'b1;

   // Reset values
   localparam logic [LG_CSR_W-1:0]  RST_TILE_SIZE_LOG2 = 3'd5;
   localparam logic                 RST_LIGHTING_MODE  = LT_PIXEL_BEST;
   localparam logic [DIM_CSR_W-1:0] RST_MAP_DIM        = 7'd11;

   localparam logic [DARK_W-1:0] DARK_FULL = 8'd255;
   localparam logic [DARK_W-1:0] DARK_NONE = 8'd0;

   // Neighbor flag bits
   localparam int NBR_UP    = 0;
   localparam int NBR_RIGHT = 1;
   localparam int NBR_DOWN  = 2;
   localparam int NBR_LEFT  = 3;

   typedef enum logic [1:0] {
      ACT_LEAVE  = 2'd0,
      ACT_BLEND  = 2'd1,
      ACT_OPAQUE = 2'd2
   } action_type;

endpackage

// File: hw/rtl/tile_darkness_gradient_shader_core.sv
// ============================================================================
// tile_darkness_gradient_shader_core
// Darkening overlay for one pixel of a map tile: opaque, blend or leave.
// ============================================================================
//
//   channel   ports                         handshake
//   --------  ----------------------------  ---------------------------------
//   request   start, busy, req_*            taken when start && !busy
//   response  rsp_valid, rsp_action/alpha   one-cycle strobe, cannot stall
//   config    csr_we, csr_index, csr_wdata  written when csr_we is high
//
// A new transaction can be taken every cycle; busy is high only during reset.
// The response passes through five register stages after the transaction
// is taken: neighbor select, weight select, multiply, sum-and-shift,
// resolve. Sustained rate is one pixel per clock outside reset.
// Reset clears the stage valid bits and loads the register defaults;
// any transaction in flight is dropped. No stall path exists downstream.
//
module tile_darkness_gradient_shader_core #(
   parameter int MAX_TILE_LOG2 = 7,
   parameter int MAX_MAP_DIM   = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               start,
   output logic                               busy,
   input  logic [tdgs_pkg::TILE_W-1:0]        req_tile_x,
   input  logic [tdgs_pkg::TILE_W-1:0]        req_tile_y,
   input  logic [tdgs_pkg::PIX_W-1:0]         req_pixel_x,
   input  logic [tdgs_pkg::PIX_W-1:0]         req_pixel_y,
   input  logic [tdgs_pkg::DARK_W-1:0]        req_dark_center,
   input  logic [tdgs_pkg::DARK_W-1:0]        req_dark_up,
   input  logic [tdgs_pkg::DARK_W-1:0]        req_dark_right,
   input  logic [tdgs_pkg::DARK_W-1:0]        req_dark_down,
   input  logic [tdgs_pkg::DARK_W-1:0]        req_dark_left,
   input  logic [tdgs_pkg::NBR_W-1:0]         req_neighbor_valid,
   // response
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_action,
   output logic [tdgs_pkg::DARK_W-1:0]        rsp_alpha,
   // configuration
   input  logic                               csr_we,
   input  logic [tdgs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tdgs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tdgs_pkg::*;

   // Pixel positions, weights and tile log2 widths follow the largest tile
   localparam int POS_W  = MAX_TILE_LOG2;
   localparam int LG_W   = $clog2(MAX_TILE_LOG2 + 1);
   localparam int PROD_W = DARK_W + POS_W;
   localparam int SUM_W  = PROD_W + 1;
   // Edge compares hold tile+1, the map width register and the clamp bound
   localparam int DIM_BND_W = $clog2(MAX_MAP_DIM + 1);
   localparam int DIM_W     = (DIM_BND_W > DIM_CSR_W) ? DIM_BND_W : DIM_CSR_W + 1;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [LG_CSR_W-1:0]  tile_size_log2_ff;
   logic                 lighting_mode_ff;
   logic [DIM_CSR_W-1:0] map_width_ff;
   logic [DIM_CSR_W-1:0] map_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_size_log2_ff <= RST_TILE_SIZE_LOG2;
         lighting_mode_ff  <= RST_LIGHTING_MODE;
         map_width_ff      <= RST_MAP_DIM;
         map_height_ff     <= RST_MAP_DIM;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TILE_SIZE_LOG2: tile_size_log2_ff <= csr_wdata[LG_CSR_W-1:0];
            CSR_LIGHTING_MODE:  lighting_mode_ff  <= csr_wdata[0];
            CSR_MAP_WIDTH:      map_width_ff      <= csr_wdata;
            CSR_MAP_HEIGHT:     map_height_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // No backpressure: a transaction is taken in every cycle with start high outside reset
   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   // ------------------------------------------------------------------
   // Stage 1: clamp tile size, wrap pixel, substitute missing neighbors
   // ------------------------------------------------------------------
   logic [LG_RAW_W-1:0]  lg_raw;
   logic [LG_W-1:0]      lg_in;
   logic [POS_W:0]       size_in;
   logic [POS_W-1:0]     mask_in;
   logic [DIM_W-1:0]     mw_in, mh_in, tx1_in, ty1_in;
   logic                 up_ok, right_ok, down_ok, left_ok;

   logic                 s1_valid_ff;
   logic [LG_W-1:0]      s1_lg_ff;
   logic [POS_W-1:0]     s1_px_ff, s1_py_ff;
   logic [DARK_W-1:0]    s1_d0_ff, s1_du_ff, s1_dr_ff, s1_dd_ff, s1_dl_ff;

   always_comb begin
      lg_raw = LG_RAW_W'(tile_size_log2_ff);
      if (lg_raw == '0)
         lg_in = LG_W'(1);
      else if (lg_raw > LG_RAW_W'(MAX_TILE_LOG2))
         lg_in = LG_W'(MAX_TILE_LOG2);
      else
         lg_in = LG_W'(lg_raw);
      size_in = (POS_W + 1)'(1) << lg_in;
      mask_in = POS_W'(size_in - (POS_W + 1)'(1));

      mw_in  = (DIM_W'(map_width_ff) > DIM_W'(MAX_MAP_DIM)) ?
               DIM_W'(MAX_MAP_DIM) : DIM_W'(map_width_ff);
      mh_in  = (DIM_W'(map_height_ff) > DIM_W'(MAX_MAP_DIM)) ?
               DIM_W'(MAX_MAP_DIM) : DIM_W'(map_height_ff);
      tx1_in = DIM_W'(req_tile_x) + DIM_W'(1);
      ty1_in = DIM_W'(req_tile_y) + DIM_W'(1);

      up_ok    = (req_tile_y != '0) && req_neighbor_valid[NBR_UP];
      right_ok = (tx1_in < mw_in)   && req_neighbor_valid[NBR_RIGHT];
      down_ok  = (ty1_in < mh_in)   && req_neighbor_valid[NBR_DOWN];
      left_ok  = (req_tile_x != '0) && req_neighbor_valid[NBR_LEFT];
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= accept;
   end

   always_ff @(posedge clock) begin
      s1_lg_ff <= lg_in;
      s1_px_ff <= POS_W'(req_pixel_x) & mask_in;
      s1_py_ff <= POS_W'(req_pixel_y) & mask_in;
      s1_d0_ff <= req_dark_center;
      s1_du_ff <= up_ok    ? req_dark_up    : req_dark_center;
      s1_dr_ff <= right_ok ? req_dark_right : req_dark_center;
      s1_dd_ff <= down_ok  ? req_dark_down  : req_dark_center;
      s1_dl_ff <= left_ok  ? req_dark_left  : req_dark_center;
   end

   // ------------------------------------------------------------------
   // Stage 2: pick ramp segment and its two weights per axis
   // ------------------------------------------------------------------
   logic [POS_W:0]    size2_in;
   logic [POS_W-1:0]  half2_in;
   logic              below_x, below_y;
   logic              flat_in;

   logic              s2_valid_ff;
   logic              s2_flat_ff;
   logic [LG_W-1:0]   s2_hs_ff;
   logic [DARK_W-1:0] s2_d0_ff;
   logic [DARK_W-1:0] s2_xa_ff, s2_xb_ff, s2_ya_ff, s2_yb_ff;
   logic [POS_W-1:0]  s2_xwa_ff, s2_xwb_ff, s2_ywa_ff, s2_ywb_ff;

   always_comb begin
      size2_in = (POS_W + 1)'(1) << s1_lg_ff;
      half2_in = POS_W'(size2_in >> 1);
      below_x  = s1_px_ff < half2_in;
      below_y  = s1_py_ff < half2_in;
      flat_in  = (lighting_mode_ff == LT_TILE) ||
                 ((s1_du_ff == s1_d0_ff) && (s1_dr_ff == s1_d0_ff) &&
                  (s1_dd_ff == s1_d0_ff) && (s1_dl_ff == s1_d0_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      s2_flat_ff <= flat_in;
      s2_hs_ff   <= s1_lg_ff - LG_W'(1);
      s2_d0_ff   <= s1_d0_ff;
      // left half runs edge->center, right half center->far edge
      s2_xa_ff   <= below_x ? s1_dl_ff : s1_d0_ff;
      s2_xb_ff   <= below_x ? s1_d0_ff : s1_dr_ff;
      s2_xwa_ff  <= below_x ? half2_in - s1_px_ff :
                              POS_W'(size2_in - (POS_W + 1)'(s1_px_ff));
      s2_xwb_ff  <= below_x ? s1_px_ff : s1_px_ff - half2_in;
      s2_ya_ff   <= below_y ? s1_du_ff : s1_d0_ff;
      s2_yb_ff   <= below_y ? s1_d0_ff : s1_dd_ff;
      s2_ywa_ff  <= below_y ? half2_in - s1_py_ff :
                              POS_W'(size2_in - (POS_W + 1)'(s1_py_ff));
      s2_ywb_ff  <= below_y ? s1_py_ff : s1_py_ff - half2_in;
   end

   // ------------------------------------------------------------------
   // Stage 3: weight products, one small multiplier per term
   // ------------------------------------------------------------------
   logic              s3_valid_ff;
   logic              s3_flat_ff;
   logic [LG_W-1:0]   s3_hs_ff;
   logic [DARK_W-1:0] s3_d0_ff;
   logic [PROD_W-1:0] s3_xpa_ff, s3_xpb_ff, s3_ypa_ff, s3_ypb_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      s3_flat_ff <= s2_flat_ff;
      s3_hs_ff   <= s2_hs_ff;
      s3_d0_ff   <= s2_d0_ff;
      s3_xpa_ff  <= PROD_W'(s2_xa_ff) * PROD_W'(s2_xwa_ff);
      s3_xpb_ff  <= PROD_W'(s2_xb_ff) * PROD_W'(s2_xwb_ff);
      s3_ypa_ff  <= PROD_W'(s2_ya_ff) * PROD_W'(s2_ywa_ff);
      s3_ypb_ff  <= PROD_W'(s2_yb_ff) * PROD_W'(s2_ywb_ff);
   end

   // ------------------------------------------------------------------
   // Stage 4: sum each axis and scale back by half the tile edge
   // ------------------------------------------------------------------
   logic [SUM_W-1:0]  gx_sum_in, gy_sum_in;

   logic              s4_valid_ff;
   logic              s4_flat_ff;
   logic [DARK_W-1:0] s4_d0_ff;
   logic [DARK_W-1:0] s4_gx_ff, s4_gy_ff;

   assign gx_sum_in = SUM_W'(s3_xpa_ff) + SUM_W'(s3_xpb_ff);
   assign gy_sum_in = SUM_W'(s3_ypa_ff) + SUM_W'(s3_ypb_ff);

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else       s4_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      s4_flat_ff <= s3_flat_ff;
      s4_d0_ff   <= s3_d0_ff;
      s4_gx_ff   <= DARK_W'(gx_sum_in >> s3_hs_ff);
      s4_gy_ff   <= DARK_W'(gy_sum_in >> s3_hs_ff);
   end

   // ------------------------------------------------------------------
   // Stage 5: resolve action and alpha into the response register
   // ------------------------------------------------------------------
   logic [DARK_W:0]   avg_sum_in;
   action_type        action_in;
   logic [DARK_W-1:0] alpha_in;

   logic              rsp_valid_ff;
   action_type        rsp_action_ff;
   logic [DARK_W-1:0] rsp_alpha_ff;

   always_comb begin
      avg_sum_in = (DARK_W + 1)'(s4_gx_ff) + (DARK_W + 1)'(s4_gy_ff);
      if (!s4_flat_ff) begin
         action_in = ACT_BLEND;
         alpha_in  = avg_sum_in[DARK_W:1];
      end else if (s4_d0_ff == DARK_FULL) begin
         action_in = ACT_OPAQUE;
         alpha_in  = DARK_NONE;
      end else if (s4_d0_ff != DARK_NONE) begin
         action_in = ACT_BLEND;
         alpha_in  = s4_d0_ff;
      end else begin
         action_in = ACT_LEAVE;
         alpha_in  = DARK_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= s4_valid_ff;
   end

   always_ff @(posedge clock) begin
      rsp_action_ff <= action_in;
      rsp_alpha_ff  <= alpha_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_action = rsp_action_ff;
   assign rsp_alpha  = rsp_alpha_ff;

endmodule

// File: hw/rtl/tdgs_checker.sv
// ============================================================================
// tdgs_checker
// Port-level checks on transaction flow and response encoding.
// ============================================================================
module tdgs_checker #(
   parameter int LATENCY = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic                        rsp_valid,
   input  logic [1:0]                  rsp_action,
   input  logic [tdgs_pkg::DARK_W-1:0] rsp_alpha
);
   import tdgs_pkg::*;

   // every taken transaction yields a response after the fixed latency
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("response missing after accepted transaction");

   // no response without a transaction taken the fixed latency earlier
   a_rsp_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("response without matching transaction");

   // alpha carries a value only for blends
   a_alpha_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_action != ACT_BLEND)) |-> (rsp_alpha == DARK_NONE))
      else $error("nonzero alpha outside blend");

   // reset drops everything in flight
   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

endmodule

bind tile_darkness_gradient_shader_core tdgs_checker u_tdgs_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_action (rsp_action),
   .rsp_alpha  (rsp_alpha)
);

// File: tb/tile_darkness_gradient_shader_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tile_darkness_gradient_shader_core_tb
// Self-checking bench for the per-pixel tile darkening overlay.
// A short directed pass covers field extremes, uniform tiles and map edges.
// Randomized pixels then run under several register settings and input
// gap rates. A scoreboard predicts action and alpha for every accepted
// transaction and compares each response strobe in order.
// ============================================================================
module tile_darkness_gradient_shader_core_tb;
   import tdgs_pkg::*;

   localparam int TILE_LOG2_LIMIT = 7;
   localparam int MAP_DIM_LIMIT   = 64;
   localparam int PIPE_DEPTH      = 5;      // request to response, in clocks
   localparam int PHASE_PIXELS    = 165;

   typedef struct packed {
      logic [TILE_W-1:0] tile_x;
      logic [TILE_W-1:0] tile_y;
      logic [PIX_W-1:0]  pixel_x;
      logic [PIX_W-1:0]  pixel_y;
      logic [DARK_W-1:0] dark_center;
      logic [DARK_W-1:0] dark_up;
      logic [DARK_W-1:0] dark_right;
      logic [DARK_W-1:0] dark_down;
      logic [DARK_W-1:0] dark_left;
      logic [NBR_W-1:0]  neighbor_valid;
   } pixel_req_type;

   typedef struct packed {
      action_type        action;
      logic [DARK_W-1:0] alpha;
   } shade_type;

   // Scoreboard: shadow registers, overlay predictor, in-order shade queue
   class overlay_checker;
      int unsigned tile_lg;
      logic        lit_mode;
      int unsigned map_w;
      int unsigned map_h;
      int          fails;
      shade_type   expected_shades[$];

      function new();
         tile_lg  = RST_TILE_SIZE_LOG2;
         lit_mode = RST_LIGHTING_MODE;
         map_w    = RST_MAP_DIM;
         map_h    = RST_MAP_DIM;
         fails    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_TILE_SIZE_LOG2: tile_lg  = data[LG_CSR_W-1:0];
            CSR_LIGHTING_MODE:  lit_mode = data[0];
            CSR_MAP_WIDTH:      map_w    = data[DIM_CSR_W-1:0];
            CSR_MAP_HEIGHT:     map_h    = data[DIM_CSR_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned clamped_lg();
         if (tile_lg < 1) return 1;
         if (tile_lg > TILE_LOG2_LIMIT) return TILE_LOG2_LIMIT;
         return tile_lg;
      endfunction

      // Piecewise linear blend lo -> mid over the first half, mid -> hi after
      function int unsigned ramp_level(int unsigned lo, int unsigned mid, int unsigned hi,
                                       int unsigned pos, int unsigned lg);
         int unsigned span;
         int unsigned half;
         span = 1 << lg;
         half = span >> 1;
         if (pos < half) return (lo * (half - pos) + mid * pos) >> (lg - 1);
         return (mid * (span - pos) + hi * (pos - half)) >> (lg - 1);
      endfunction

      function shade_type shade_pixel(pixel_req_type r);
         int unsigned lg, mw, mh, px, py, tx, ty;
         int unsigned d0, du, dr, dd, dl, gx, gy;
         shade_type s;
         lg = clamped_lg();
         mw = (map_w > MAP_DIM_LIMIT) ? MAP_DIM_LIMIT : map_w;
         mh = (map_h > MAP_DIM_LIMIT) ? MAP_DIM_LIMIT : map_h;
         px = r.pixel_x & ((1 << lg) - 1);
         py = r.pixel_y & ((1 << lg) - 1);
         tx = r.tile_x;
         ty = r.tile_y;
         d0 = r.dark_center;
         du = r.dark_up;
         dr = r.dark_right;
         dd = r.dark_down;
         dl = r.dark_left;
         // Off-map or flagged-off neighbors fall back to the center darkness
         if (ty == 0 || !r.neighbor_valid[NBR_UP])        du = d0;
         if (tx + 1 >= mw || !r.neighbor_valid[NBR_RIGHT]) dr = d0;
         if (ty + 1 >= mh || !r.neighbor_valid[NBR_DOWN])  dd = d0;
         if (tx == 0 || !r.neighbor_valid[NBR_LEFT])       dl = d0;
         s.action = ACT_LEAVE;
         s.alpha  = '0;
         if (lit_mode == LT_TILE || (du == d0 && dr == d0 && dd == d0 && dl == d0)) begin
            if (d0 == DARK_FULL) begin
               s.action = ACT_OPAQUE;
            end else if (d0 != DARK_NONE) begin
               s.action = ACT_BLEND;
               s.alpha  = d0;
            end
         end else begin
            gx = ramp_level(dl, d0, dr, px, lg);
            gy = ramp_level(du, d0, dd, py, lg);
            s.action = ACT_BLEND;
            s.alpha  = DARK_W'((gx + gy) >> 1);
         end
         return s;
      endfunction

      function void note_pixel(pixel_req_type r);
         expected_shades.push_back(shade_pixel(r));
      endfunction

      function int pending();
         return expected_shades.size();
      endfunction

      task report(string what);
         if (fails < 40) $display("%0t ns  ERROR  %s", $time, what);
         fails++;
      endtask

      task check_shade(logic [1:0] act, logic [DARK_W-1:0] alpha);
         shade_type want;
         if (expected_shades.size() == 0) begin
            report($sformatf("response with nothing pending: action %0d alpha %0d",
                             act, alpha));
            return;
         end
         want = expected_shades.pop_front();
         if (act !== want.action)
            report($sformatf("action %0d, predicted %s", act, want.action.name()));
         if (alpha !== want.alpha)
            report($sformatf("alpha %0d, predicted %0d", alpha, want.alpha));
      endtask

      task flush_pending();
         while (expected_shades.size() != 0) begin
            report($sformatf("no response for predicted action %s alpha %0d",
                             expected_shades[0].action.name(), expected_shades[0].alpha));
            void'(expected_shades.pop_front());
         end
      endtask
   endclass

   // Drive every input to a known value from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [TILE_W-1:0]     req_tile_x = '0;
   logic [TILE_W-1:0]     req_tile_y = '0;
   logic [PIX_W-1:0]      req_pixel_x = '0;
   logic [PIX_W-1:0]      req_pixel_y = '0;
   logic [DARK_W-1:0]     req_dark_center = '0;
   logic [DARK_W-1:0]     req_dark_up = '0;
   logic [DARK_W-1:0]     req_dark_right = '0;
   logic [DARK_W-1:0]     req_dark_down = '0;
   logic [DARK_W-1:0]     req_dark_left = '0;
   logic [NBR_W-1:0]      req_neighbor_valid = '0;
   logic                  rsp_valid;
   logic [1:0]            rsp_action;
   logic [DARK_W-1:0]     rsp_alpha;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   overlay_checker board;

   tile_darkness_gradient_shader_core #(
      .MAX_TILE_LOG2 (TILE_LOG2_LIMIT),
      .MAX_MAP_DIM   (MAP_DIM_LIMIT)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_tile_x         (req_tile_x),
      .req_tile_y         (req_tile_y),
      .req_pixel_x        (req_pixel_x),
      .req_pixel_y        (req_pixel_y),
      .req_dark_center    (req_dark_center),
      .req_dark_up        (req_dark_up),
      .req_dark_right     (req_dark_right),
      .req_dark_down      (req_dark_down),
      .req_dark_left      (req_dark_left),
      .req_neighbor_valid (req_neighbor_valid),
      .rsp_valid          (rsp_valid),
      .rsp_action         (rsp_action),
      .rsp_alpha          (rsp_alpha),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Monitor: all inputs change by nonblocking assignment at the edge, so
   // sampling here sees the values the block itself registers
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) board.write_reg(csr_index, csr_wdata);
         if (start && !busy)
            board.note_pixel('{req_tile_x, req_tile_y, req_pixel_x, req_pixel_y,
                               req_dark_center, req_dark_up, req_dark_right,
                               req_dark_down, req_dark_left, req_neighbor_valid});
         if (rsp_valid) board.check_shade(rsp_action, rsp_alpha);
      end
   end

   // Present one transaction, hold it until taken, then idle at the given rate
   task automatic send_pixel(pixel_req_type r, int idle_pct);
      start              <= 1'b1;
      req_tile_x         <= r.tile_x;
      req_tile_y         <= r.tile_y;
      req_pixel_x        <= r.pixel_x;
      req_pixel_y        <= r.pixel_y;
      req_dark_center    <= r.dark_center;
      req_dark_up        <= r.dark_up;
      req_dark_right     <= r.dark_right;
      req_dark_down      <= r.dark_down;
      req_dark_left      <= r.dark_left;
      req_neighbor_valid <= r.neighbor_valid;
      do @(posedge clock); while (busy);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // Write all four registers on back-to-back edges; only call while drained
   task automatic program_regs(int unsigned lg, int unsigned mode, int unsigned w,
                               int unsigned h);
      logic [CSR_DATA_W-1:0] vals[4];
      vals[CSR_TILE_SIZE_LOG2] = CSR_DATA_W'(lg);
      vals[CSR_LIGHTING_MODE]  = CSR_DATA_W'(mode);
      vals[CSR_MAP_WIDTH]      = CSR_DATA_W'(w);
      vals[CSR_MAP_HEIGHT]     = CSR_DATA_W'(h);
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Drop start and hold until every predicted response has come back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   function automatic pixel_req_type mk_pixel(int tx, int ty, int px, int py, int c, int u,
                                              int r, int d, int l, int v);
      return '{TILE_W'(tx), TILE_W'(ty), PIX_W'(px), PIX_W'(py), DARK_W'(c), DARK_W'(u),
               DARK_W'(r), DARK_W'(d), DARK_W'(l), NBR_W'(v)};
   endfunction

   // Neighbor darkness: often equal to center so uniform tiles show up
   function automatic logic [DARK_W-1:0] near_dark(logic [DARK_W-1:0] c);
      int unsigned pick;
      pick = $urandom_range(19);
      if (pick < 6)  return c;
      if (pick < 8)  return DARK_NONE;
      if (pick < 10) return DARK_FULL;
      if (pick < 13) return c + DARK_W'($urandom_range(2)) - DARK_W'(1);
      return DARK_W'($urandom);
   endfunction

   // Tile coordinate biased toward the map edges the block tests against
   function automatic logic [TILE_W-1:0] edge_coord(int unsigned dim);
      case ($urandom_range(7))
         0: return '0;
         1: return TILE_W'(dim - 1);
         2: return TILE_W'(dim);
         3: return TILE_W'(dim - 2);
         default: return TILE_W'($urandom);
      endcase
   endfunction

   function automatic pixel_req_type random_pixel();
      pixel_req_type r;
      int unsigned   span;
      span = 1 << board.clamped_lg();
      r.tile_x  = edge_coord(board.map_w);
      r.tile_y  = edge_coord(board.map_h);
      // mostly inside the tile; the rest exercises wraparound
      r.pixel_x = ($urandom_range(4) == 0) ? PIX_W'($urandom) : PIX_W'($urandom_range(span - 1));
      r.pixel_y = ($urandom_range(4) == 0) ? PIX_W'($urandom) : PIX_W'($urandom_range(span - 1));
      case ($urandom_range(9))
         0: r.dark_center = DARK_NONE;
         1: r.dark_center = DARK_FULL;
         default: r.dark_center = DARK_W'($urandom);
      endcase
      r.dark_up    = near_dark(r.dark_center);
      r.dark_right = near_dark(r.dark_center);
      r.dark_down  = near_dark(r.dark_center);
      r.dark_left  = near_dark(r.dark_center);
      r.neighbor_valid = ($urandom_range(9) < 6) ? {NBR_W{1'b1}} : NBR_W'($urandom);
      return r;
   endfunction

   // Register settings per phase: log2, mode, width, height, input idle rate
   int unsigned phase_cfg[10][5] = '{
      '{1, 1, 64,  64,  0},
      '{7, 1, 1,   1,   52},
      '{0, 1, 0,   0,   38},
      '{3, 0, 8,   5,   0},
      '{2, 1, 127, 3,   52},
      '{4, 1, 13,  64,  38},
      '{6, 0, 127, 0,   52},
      '{5, 1, 11,  11,  0},
      '{7, 1, 40,  22,  38},
      '{3, 1, 2,   127, 52}
   };

   initial begin
      pixel_req_type directed[$];
      int            guard;
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed pass at reset settings: 32-pixel tiles, gradient mode, 11x11 map
      directed.push_back(mk_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));           // leave
      directed.push_back(mk_pixel(5, 5, 3, 3, 255, 255, 255, 255, 255, 15)); // opaque
      directed.push_back(mk_pixel(5, 5, 3, 3, 77, 77, 77, 77, 77, 15));      // uniform blend
      directed.push_back(mk_pixel(5, 5, 9, 20, 100, 0, 255, 0, 255, 0));     // flags all off
      directed.push_back(mk_pixel(5, 5, 16, 16, 255, 255, 255, 255, 0, 15)); // gradient 255
      directed.push_back(mk_pixel(5, 5, 16, 16, 0, 0, 0, 0, 255, 15));       // gradient 0
      directed.push_back(mk_pixel(5, 5, 0, 0, 128, 0, 255, 255, 0, 15));     // tile corner
      directed.push_back(mk_pixel(5, 5, 31, 31, 128, 0, 255, 255, 0, 15));   // far corner
      directed.push_back(mk_pixel(5, 5, 127, 127, 60, 200, 10, 90, 250, 15)); // wrap
      directed.push_back(mk_pixel(5, 5, 64, 96, 60, 200, 10, 90, 250, 15));  // wrap to 0
      directed.push_back(mk_pixel(0, 0, 7, 25, 40, 255, 255, 255, 255, 15)); // top-left edge
      directed.push_back(mk_pixel(10, 10, 25, 7, 40, 0, 0, 0, 0, 15));       // bottom-right
      directed.push_back(mk_pixel(63, 63, 12, 12, 200, 0, 0, 0, 0, 15));     // outside map
      directed.push_back(mk_pixel(0, 63, 12, 12, 200, 0, 0, 0, 0, 15));      // up and right live
      directed.push_back(mk_pixel(4, 4, 5, 27, 90, 10, 250, 250, 250, 1));   // up alone
      directed.push_back(mk_pixel(4, 4, 27, 5, 90, 250, 10, 250, 250, 2));   // right alone
      directed.push_back(mk_pixel(4, 4, 5, 27, 90, 250, 250, 10, 250, 4));   // down alone
      directed.push_back(mk_pixel(4, 4, 5, 27, 90, 250, 250, 250, 10, 8));   // left alone
      directed.push_back(mk_pixel(3, 3, 1, 1, 0, 255, 255, 255, 255, 15));   // dark ring
      directed.push_back(mk_pixel(3, 3, 30, 30, 255, 0, 0, 0, 0, 15));      // lit ring
      directed.push_back(mk_pixel(9, 9, 15, 17, 1, 2, 0, 1, 1, 15));         // near uniform
      directed.push_back(mk_pixel(42, 21, 85, 42, 170, 85, 170, 85, 170, 10)); // alt bits
      foreach (directed[i]) send_pixel(directed[i], 0);
      drain();

      // Randomized phases, each behind a fresh register setting
      foreach (phase_cfg[p]) begin
         program_regs(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            // stretches inside idle phases run with no gaps at all
            send_pixel(random_pixel(), ((n / 40) % 2 == 1) ? 0 : int'(phase_cfg[p][4]));
         end
         drain();
      end

      // Catch late or extra responses, then call anything still pending lost
      guard = 0;
      while (board.pending() != 0 && guard < 200) begin
         @(posedge clock);
         guard++;
      end
      repeat (PIPE_DEPTH + 3) @(posedge clock);
      board.flush_pending();
      if (board.fails == 0) begin
         $display("tile_darkness_gradient_shader_core: match");
      end else begin
         $display("tile_darkness_gradient_shader_core: mismatch");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #5000000;
      $display("tile_darkness_gradient_shader_core: mismatch");
      $finish;
   end

endmodule
